### hdl/vrl_pkg.sv
// ----------------------------------------------------------------------------
// vrl_pkg: shared types and constants for the vector rescale pipeline
// Widths, pipeline depths and stage payload structs.
// ----------------------------------------------------------------------------
package vrl_pkg;

    localparam int FracBits  = 16;
    localparam int Lanes     = 3;
    localparam int SqrtSteps = 32;
    localparam int DivSteps  = 32;
    // mag, square, sum, sqrt steps, round, multiply, add, divide steps, output
    localparam int PipeDepth = SqrtSteps + DivSteps + 7;

    localparam logic [30:0] TargetReset = 31'(1) << FracBits;

    typedef struct packed {
        logic [Lanes-1:0] neg;
        logic             last;
        logic             zero;
    } t_tag;

    typedef struct packed {
        t_tag                        tag;
        logic [Lanes-1:0][31:0]      mag;
    } t_sq_side;

endpackage

### hdl/vrl_sqrt.sv
// ----------------------------------------------------------------------------
// vrl_sqrt: pipelined integer square root
// One root bit per stage; gives floor(sqrt) and the remainder s - root^2.
// ----------------------------------------------------------------------------
module vrl_sqrt (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [63:0]       i_rad,
    input  vrl_pkg::t_sq_side i_side,
    output logic [31:0]       o_root,
    output logic [34:0]       o_rem,
    output vrl_pkg::t_sq_side o_side
);

    logic [63:0]       w_rad  [vrl_pkg::SqrtSteps+1];
    logic [34:0]       w_rem  [vrl_pkg::SqrtSteps+1];
    logic [31:0]       w_root [vrl_pkg::SqrtSteps+1];
    vrl_pkg::t_sq_side w_side [vrl_pkg::SqrtSteps+1];

    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < vrl_pkg::SqrtSteps; k++) begin : g_step
        logic [34:0]       cand;
        logic [34:0]       trial;
        logic [63:0]       n_rad;
        logic [34:0]       n_rem;
        logic [31:0]       n_root;
        logic [63:0]       r_rad;
        logic [34:0]       r_rem;
        logic [31:0]       r_root;
        vrl_pkg::t_sq_side r_side;

        always_comb begin
            cand  = {w_rem[k][32:0], w_rad[k][63:62]};
            trial = {1'b0, w_root[k], 2'b01};
            n_rad = {w_rad[k][61:0], 2'b00};
            if (cand >= trial) begin
                n_rem  = cand - trial;
                n_root = {w_root[k][30:0], 1'b1};
            end else begin
                n_rem  = cand;
                n_root = {w_root[k][30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= n_rad;
                r_rem  <= n_rem;
                r_root <= n_root;
                r_side <= w_side[k];
            end
        end

        assign w_rad[k+1]  = r_rad;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
    end

    assign o_root = w_root[vrl_pkg::SqrtSteps];
    assign o_rem  = w_rem[vrl_pkg::SqrtSteps];
    assign o_side = w_side[vrl_pkg::SqrtSteps];

endmodule

### hdl/vrl_div.sv
// ----------------------------------------------------------------------------
// vrl_div: pipelined restoring divider, three lanes, shared divisor
// 64-bit dividends whose quotient fits 32 bits; one quotient bit per stage.
// ----------------------------------------------------------------------------
module vrl_div (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [vrl_pkg::Lanes-1:0][63:0]      i_num,
    input  logic [31:0]                          i_den,
    input  vrl_pkg::t_tag                        i_tag,
    output logic [vrl_pkg::Lanes-1:0][31:0]      o_quo,
    output vrl_pkg::t_tag                        o_tag
);

    logic [vrl_pkg::Lanes-1:0][31:0] w_rem [vrl_pkg::DivSteps+1];
    logic [vrl_pkg::Lanes-1:0][31:0] w_low [vrl_pkg::DivSteps+1];
    logic [vrl_pkg::Lanes-1:0][31:0] w_quo [vrl_pkg::DivSteps+1];
    logic [31:0]                     w_den [vrl_pkg::DivSteps+1];
    vrl_pkg::t_tag                   w_tag [vrl_pkg::DivSteps+1];

    always_comb begin
        for (int l = 0; l < vrl_pkg::Lanes; l++) begin
            w_rem[0][l] = i_num[l][63:32];
            w_low[0][l] = i_num[l][31:0];
        end
    end
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;
    assign w_tag[0] = i_tag;

    for (genvar k = 0; k < vrl_pkg::DivSteps; k++) begin : g_step
        logic [32:0]                     cand;
        logic [vrl_pkg::Lanes-1:0][31:0] n_rem;
        logic [vrl_pkg::Lanes-1:0][31:0] n_low;
        logic [vrl_pkg::Lanes-1:0][31:0] n_quo;
        logic [vrl_pkg::Lanes-1:0][31:0] r_rem;
        logic [vrl_pkg::Lanes-1:0][31:0] r_low;
        logic [vrl_pkg::Lanes-1:0][31:0] r_quo;
        logic [31:0]                     r_den;
        vrl_pkg::t_tag                   r_tag;

        always_comb begin
            cand = '0;
            for (int l = 0; l < vrl_pkg::Lanes; l++) begin
                cand     = {w_rem[k][l], w_low[k][l][31]};
                n_low[l] = {w_low[k][l][30:0], 1'b0};
                if (cand >= {1'b0, w_den[k]}) begin
                    n_rem[l] = 32'(cand - {1'b0, w_den[k]});
                    n_quo[l] = {w_quo[k][l][30:0], 1'b1};
                end else begin
                    n_rem[l] = cand[31:0];
                    n_quo[l] = {w_quo[k][l][30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_low <= n_low;
                r_quo <= n_quo;
                r_den <= w_den[k];
                r_tag <= w_tag[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_low[k+1] = r_low;
        assign w_quo[k+1] = r_quo;
        assign w_den[k+1] = r_den;
        assign w_tag[k+1] = r_tag;
    end

    assign o_quo = w_quo[vrl_pkg::DivSteps];
    assign o_tag = w_tag[vrl_pkg::DivSteps];

endmodule

### hdl/vector_rescale_to_length.sv
// ----------------------------------------------------------------------------
// vector_rescale_to_length: scale a 3-D Q16.16 point to a set length
// Pipeline: 32-stage sqrt, 32-stage divider and 7 further stages for
//   magnitude, squaring, sum, rounding, multiply, add and output.
// Throughput: one point per cycle; the whole pipe holds while a result
//   waits at the output register.
// Reset: synchronous active low; clears valid bits, target length to 1.0.
// ----------------------------------------------------------------------------
module vector_rescale_to_length (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_x_in,
    input  logic [31:0] i_y_in,
    input  logic [31:0] i_z_in,
    input  logic        i_last_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_x_out,
    output logic [31:0] o_y_out,
    output logic [31:0] o_z_out,
    output logic        o_zero_vector,
    output logic        o_saturated,
    output logic        o_last_out
);

    logic                                en;
    logic [30:0]                         r_len;
    logic [vrl_pkg::PipeDepth-1:0]       r_vld;

    logic [vrl_pkg::Lanes-1:0][31:0]     in_c;
    vrl_pkg::t_sq_side                   n_s1;
    vrl_pkg::t_sq_side                   r_s1;
    logic [vrl_pkg::Lanes-1:0][63:0]     r_sq;
    vrl_pkg::t_sq_side                   r_s2;
    logic [63:0]                         r_sum;
    vrl_pkg::t_sq_side                   n_s3;
    vrl_pkg::t_sq_side                   r_s3;

    logic [31:0]                         sq_root;
    logic [34:0]                         sq_rem;
    vrl_pkg::t_sq_side                   sq_side;

    logic [31:0]                         r_r;
    vrl_pkg::t_sq_side                   r_s4;
    logic [vrl_pkg::Lanes-1:0][63:0]     r_prod;
    logic [31:0]                         r_half;
    logic [31:0]                         r_den5;
    vrl_pkg::t_tag                       r_t5;
    logic [vrl_pkg::Lanes-1:0][63:0]     r_num;
    logic [31:0]                         r_den6;
    vrl_pkg::t_tag                       r_t6;

    logic [vrl_pkg::Lanes-1:0][31:0]     dv_quo;
    vrl_pkg::t_tag                       dv_tag;

    logic [vrl_pkg::Lanes-1:0][31:0]     n_out;
    logic [vrl_pkg::Lanes-1:0]           lane_sat;
    logic [vrl_pkg::Lanes-1:0][31:0]     r_out;
    logic                                r_zero;
    logic                                r_sat;
    logic                                r_last;

    assign en         = !r_vld[vrl_pkg::PipeDepth-1] || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= vrl_pkg::TargetReset;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[vrl_pkg::PipeDepth-2:0], i_in_valid};
        end
    end

    assign in_c = {i_z_in, i_y_in, i_x_in};

    always_comb begin
        n_s1          = '0;
        n_s1.tag.last = i_last_in;
        for (int l = 0; l < vrl_pkg::Lanes; l++) begin
            n_s1.tag.neg[l] = in_c[l][31];
            n_s1.mag[l]     = in_c[l][31] ? 32'(32'd0 - in_c[l]) : in_c[l];
        end
    end

    always_comb begin
        n_s3          = r_s2;
        n_s3.tag.zero = (r_sq[0] == '0) && (r_sq[1] == '0) && (r_sq[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            for (int l = 0; l < vrl_pkg::Lanes; l++) begin
                r_sq[l] <= 64'(r_s1.mag[l]) * 64'(r_s1.mag[l]);
            end
            r_s2  <= r_s1;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_s3  <= n_s3;
        end
    end

    vrl_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sum),
        .i_side (r_s3),
        .o_root (sq_root),
        .o_rem  (sq_rem),
        .o_side (sq_side)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r  <= sq_root + 32'(sq_rem > {3'b000, sq_root});
            r_s4 <= sq_side;
            for (int l = 0; l < vrl_pkg::Lanes; l++) begin
                r_prod[l] <= 64'(r_s4.mag[l]) * 64'(r_len);
            end
            r_half <= {1'b0, r_r[31:1]};
            r_den5 <= r_r;
            r_t5   <= r_s4.tag;
            for (int l = 0; l < vrl_pkg::Lanes; l++) begin
                r_num[l] <= r_prod[l] + 64'(r_half);
            end
            r_den6 <= r_den5;
            r_t6   <= r_t5;
        end
    end

    vrl_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num),
        .i_den (r_den6),
        .i_tag (r_t6),
        .o_quo (dv_quo),
        .o_tag (dv_tag)
    );

    always_comb begin
        for (int l = 0; l < vrl_pkg::Lanes; l++) begin
            lane_sat[l] = 1'b0;
            if (dv_tag.zero) begin
                n_out[l] = '0;
            end else if (dv_tag.neg[l]) begin
                if (dv_quo[l][31] && (dv_quo[l][30:0] != '0)) begin
                    lane_sat[l] = 1'b1;
                    n_out[l]    = 32'h8000_0000;
                end else begin
                    n_out[l] = 32'(32'd0 - dv_quo[l]);
                end
            end else if (dv_quo[l][31]) begin
                lane_sat[l] = 1'b1;
                n_out[l]    = 32'h7FFF_FFFF;
            end else begin
                n_out[l] = dv_quo[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out  <= n_out;
            r_zero <= dv_tag.zero;
            r_sat  <= |lane_sat;
            r_last <= dv_tag.last;
        end
    end

    assign o_out_valid   = r_vld[vrl_pkg::PipeDepth-1];
    assign o_x_out       = r_out[0];
    assign o_y_out       = r_out[1];
    assign o_z_out       = r_out[2];
    assign o_zero_vector = r_zero;
    assign o_saturated   = r_sat;
    assign o_last_out    = r_last;

endmodule

### hdl/vrl_checker.sv
// ----------------------------------------------------------------------------
// vrl_checker: port-level checks for the vector rescale block
// Output handshake, zero-vector result, saturation, flow-control and reset relations.
// ----------------------------------------------------------------------------
module vrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_x_out,
    input logic [31:0] o_y_out,
    input logic [31:0] o_z_out,
    input logic        o_zero_vector,
    input logic        o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_vector |->
            o_x_out == '0 && o_y_out == '0 && o_z_out == '0 && !o_saturated)
        else $error("zero vector result not cleared");

    a_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_saturated)
        else $error("scaled coordinate exceeded target length");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("valid result right after reset");

endmodule

bind vector_rescale_to_length vrl_checker u_vrl_checker (.*);

### dv/vector_rescale_to_length_test.sv
// ----------------------------------------------------------------------------
// vector_rescale_to_length_test: self-checking test of the point rescaler
// Drives points through the valid/ready ports with random gaps and stalls,
// predicts each rescaled point in integer arithmetic and compares per field.
// ----------------------------------------------------------------------------
module vector_rescale_to_length_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] x, y, z;
        logic        zero, sat, last;
    } t_point_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [30:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_x_in = '0, i_y_in = '0, i_z_in = '0;
    logic        i_last_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_x_out, o_y_out, o_z_out;
    logic        o_zero_vector, o_saturated, o_last_out;

    logic [30:0] target_len = vrl_pkg::TargetReset;
    t_point_out  pending_points[$];
    int          n_errors = 0;
    int          hold_cycles = 0;

    vector_rescale_to_length dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("vector_rescale_to_length: mismatch");
        $finish;
    end

    function automatic logic [63:0] root_nearest(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        if (v > res) res += 1;
        return res;
    endfunction

    function automatic logic [31:0] rescale_coord(logic [31:0] c, logic [63:0] r,
                                                  inout logic sat);
        logic [63:0] m, q;
        m = c[31] ? 64'(-$signed({32'hFFFF_FFFF, c})) : 64'(c);
        q = (m * 64'(target_len) + (r >> 1)) / r;
        if (c[31]) begin
            if (q > 64'h8000_0000) begin
                q = 64'h8000_0000;
                sat = 1'b1;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        return q[31:0];
    endfunction

    function automatic t_point_out rescale_point(logic [31:0] x, y, z, logic last);
        t_point_out p;
        logic [63:0] ax, ay, az, s, r;
        logic sat;
        ax = x[31] ? 64'(-$signed({32'hFFFF_FFFF, x})) : 64'(x);
        ay = y[31] ? 64'(-$signed({32'hFFFF_FFFF, y})) : 64'(y);
        az = z[31] ? 64'(-$signed({32'hFFFF_FFFF, z})) : 64'(z);
        s = ax * ax + ay * ay + az * az;
        sat = 1'b0;
        p.last = last;
        if (s == 0) begin
            p.x = 0; p.y = 0; p.z = 0; p.zero = 1'b1; p.sat = 1'b0;
            return p;
        end
        r = root_nearest(s);
        p.x = rescale_coord(x, r, sat);
        p.y = rescale_coord(y, r, sat);
        p.z = rescale_coord(z, r, sat);
        p.zero = 1'b0;
        p.sat = sat;
        return p;
    endfunction

    // valid stays up across back-to-back transfers; dropped only on a gap
    task automatic send_point(logic [31:0] x, y, z, logic last, int gap = -1);
        int g;
        g = (gap < 0) ? $urandom_range(0, 19) : gap;
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_x_in <= x; i_y_in <= y; i_z_in <= z; i_last_in <= last;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_points.push_back(rescale_point(x, y, z, last));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_target(logic [30:0] v);
        drain_results();
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        target_len = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            3: return 32'($signed($urandom_range(0, 2 << 17)) - (1 << 17));
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stall per transfer, plus a forced hold window
    initial begin
        int w;
        forever begin
            w = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0 || hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
                while (hold_cycles > 0) begin
                    hold_cycles--;
                    @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_point_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result transfer");
                n_errors++;
            end else begin
                e = pending_points.pop_front();
                if (o_x_out !== e.x) begin
                    $error("x_out exp %h got %h", e.x, o_x_out); n_errors++;
                end
                if (o_y_out !== e.y) begin
                    $error("y_out exp %h got %h", e.y, o_y_out); n_errors++;
                end
                if (o_z_out !== e.z) begin
                    $error("z_out exp %h got %h", e.z, o_z_out); n_errors++;
                end
                if (o_zero_vector !== e.zero) begin
                    $error("zero_vector exp %b got %b", e.zero, o_zero_vector); n_errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, o_saturated); n_errors++;
                end
                if (o_last_out !== e.last) begin
                    $error("last_out exp %b got %b", e.last, o_last_out); n_errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_point(0, 0, 0, 1'b0);
        send_point(32'h8000_0000, 0, 0, 1'b1);
        send_point(32'h7FFF_FFFF, 0, 0, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'hFFFF_FFFF, 0, 32'd1, 1'b0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 1'b1);
        send_point(0, 32'hFFFF_FFFF, 0, 1'b0);
        send_point(32'd3, 32'd4, 0, 1'b1);
        write_target(31'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b0);
        send_point(32'd1, 0, 0, 1'b1);
        send_point(0, 0, 0, 1'b1);
        write_target(31'd0);
        send_point(32'd5, 32'hFFFF_FFFB, 32'd7, 1'b0);
        send_point(0, 0, 0, 1'b0);
    endtask

    task automatic test_random(int n);
        repeat (n) send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (120) send_point(rand_coord(), rand_coord(), rand_coord(),
                                1'($urandom), 0);
        drain_results();
        repeat (30) send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_target(vrl_pkg::TargetReset);
        test_random(300);
        write_target(31'($urandom));
        test_random(300);
        write_target(31'd1);
        test_random(150);
        write_target(31'($urandom_range(0, 1 << 20)));
        test_backpressure();
        write_target(31'h7FFF_FFFF);
        test_random(300);
        write_target(31'h4000_0000);
        test_random(100);
        drain_results();
        if (n_errors == 0)
            $display("vector_rescale_to_length: match");
        else
            $display("vector_rescale_to_length: mismatch");
        $finish;
    end
endmodule
